### rtl/pfa_pkg.sv
// ----------------------------------------------------------------
// pfa_pkg
// shared sizes, codes and controller/datapath types of the page frame allocator
// ----------------------------------------------------------------
package pfa_pkg;

	localparam int FREE_DEPTH   = 1024;
	localparam int REGION_SLOTS = 32;
	localparam int MAX_RUN      = 64;
	localparam int FRAME_BITS   = 40;

	localparam int TOP_W  = $clog2(FREE_DEPTH + 1);
	localparam int ADDR_W = $clog2(FREE_DEPTH);
	localparam int REG_W  = $clog2(REGION_SLOTS + 1);
	localparam int RIDX_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
	localparam int CNT_W  = 7;
	localparam int OP_W   = 2;
	localparam int ST_W   = 3;

	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

	localparam logic [ST_W-1:0] ST_OK   = 3'd0;
	localparam logic [ST_W-1:0] ST_OOM  = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL = 3'd2;
	localparam logic [ST_W-1:0] ST_OVF  = 3'd3;
	localparam logic [ST_W-1:0] ST_ZERO = 3'd4;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_ADD_REGION,
		CMD_FAIL_ZERO,
		CMD_FAIL_OOM,
		CMD_OVERFLOW,
		CMD_PUSH,
		CMD_POP_RD,
		CMD_POP_DONE,
		CMD_SCAN_INIT,
		CMD_SCAN_RD,
		CMD_SCAN_CHK,
		CMD_MV_RD,
		CMD_MV_WR,
		CMD_MV_DONE,
		CMD_RG_INIT,
		CMD_RG_NEXT,
		CMD_RG_TAKE,
		CMD_PUBLISH
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            cnt_zero;
		logic            cnt_one;
		logic            top_zero;
		logic            stack_ok;
		logic            full;
		logic            pushed_all;
		logic            scan_hit;
		logic            scan_last;
		logic            mv_done;
		logic            rg_end;
		logic            rg_fit;
		logic            out_free;
	} dp_stat_t;

endpackage

### rtl/page_frame_allocator.sv
// ----------------------------------------------------------------
// page_frame_allocator
// physical page allocator over a lifo free stack and a bump region table
//
// input words (s_*) carry one request: op in s_tuser (0 add region,
// 1 free pages, 2 allocate pages), the frame numbers and a page count in
// s_tdata. every request gives exactly one output word (m_*): status and
// first allocated frame in m_tdata, from-stack flag in m_tuser.
// requests are handled one at a time; s_tready is high only while idle.
// steps of a request, from accept to output word:
//   add region            checked and entered in the region table
//   free n pages          one stack write a cycle, until the stack is full
//   allocate one page     a pop of the stack top when the stack is not empty
//   allocate n pages      a read and a check per stack entry scanned from the top,
//                         then a read and a write per entry moved down to close the gap,
//                         then region slots examined in turn if the stack fails
// the single stack ram port pair makes each scan step and each move a separate read and write.
// reset empties the stack and the region table at once; no clearing pass.
// a finished word waits in the output register while the receiver stalls;
// the next request is accepted meanwhile and holds until that word is taken.
// ----------------------------------------------------------------
module page_frame_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,  // first_page[39:0], end_page[79:40], page_count[86:80]
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // status[2:0], page_out[42:3]
	output logic        m_tuser   // from_free_stack
);
	import pfa_pkg::*;

	dp_cmd_t               cmd;
	dp_stat_t              stat;
	logic [ST_W-1:0]       out_status;
	logic [FRAME_BITS-1:0] out_page;
	logic                  out_stk;

	// sequencer
	pfa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// stack, regions and output register
	pfa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op        (s_tuser),
		.first_page(s_tdata[39:0]),
		.end_page  (s_tdata[79:40]),
		.page_count(s_tdata[86:80]),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_status(out_status),
		.out_page  (out_page),
		.out_stk   (out_stk),
		.stat      (stat)
	);

	assign m_tdata = {5'd0, out_page, out_status};
	assign m_tuser = out_stk;

endmodule

### rtl/pfa_ram.sv
// ----------------------------------------------------------------
// pfa_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------
module pfa_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/pfa_dp.sv
// ----------------------------------------------------------------
// pfa_dp
// datapath: free stack ram, region table, counters and result words
// ----------------------------------------------------------------
module pfa_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pfa_pkg::dp_cmd_t                  cmd,
	input  logic [pfa_pkg::OP_W-1:0]          op,
	input  logic [pfa_pkg::FRAME_BITS-1:0]    first_page,
	input  logic [pfa_pkg::FRAME_BITS-1:0]    end_page,
	input  logic [pfa_pkg::CNT_W-1:0]         page_count,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [pfa_pkg::ST_W-1:0]          out_status,
	output logic [pfa_pkg::FRAME_BITS-1:0]    out_page,
	output logic                              out_stk,
	output pfa_pkg::dp_stat_t                 stat
);
	import pfa_pkg::*;

	// captured item
	logic [OP_W-1:0]       op_q;
	logic [FRAME_BITS-1:0] first_q;
	logic [FRAME_BITS-1:0] end_q;
	logic [CNT_W-1:0]      cnt_q;

	// stack state and walk counters
	logic [TOP_W-1:0]      top_q;
	logic [CNT_W-1:0]      i_q;
	logic [ADDR_W-1:0]     k_q;
	logic [TOP_W-1:0]      src_q;
	logic [FRAME_BITS-1:0] prev_q;
	logic [CNT_W-1:0]      len_q;
	logic                  scan_first_q;

	// region table
	logic [FRAME_BITS-1:0] rg_next_q  [REGION_SLOTS];
	logic [FRAME_BITS-1:0] rg_limit_q [REGION_SLOTS];
	logic [REG_W-1:0]      used_q;
	logic [REG_W-1:0]      r_q;

	// result of the item in work, and the output word
	logic [ST_W-1:0]       res_status_q;
	logic [FRAME_BITS-1:0] res_page_q;
	logic                  res_stk_q;
	logic                  out_valid_q;
	logic [ST_W-1:0]       out_status_q;
	logic [FRAME_BITS-1:0] out_page_q;
	logic                  out_stk_q;

	logic                  ram_we;
	logic [ADDR_W-1:0]     ram_waddr;
	logic [FRAME_BITS-1:0] ram_wdata;
	logic [ADDR_W-1:0]     ram_raddr;
	logic [FRAME_BITS-1:0] ram_rdata;

	logic [TOP_W-1:0]      cnt_top;
	logic [FRAME_BITS:0]   prev_inc;
	logic [CNT_W-1:0]      new_len;
	logic                  scan_hit;
	logic [RIDX_W-1:0]     r_idx;
	logic [FRAME_BITS-1:0] cur_next;
	logic [FRAME_BITS-1:0] cur_limit;
	logic [FRAME_BITS-1:0] room;
	logic                  rg_fit;

	pfa_ram #(
		.WIDTH(FRAME_BITS),
		.DEPTH(FREE_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cnt_top = TOP_W'(cnt_q);

	// chain of frames that rise by one going deeper
	assign prev_inc = {1'b0, prev_q} + 1'b1;
	assign new_len  = (scan_first_q || ({1'b0, ram_rdata} != prev_inc)) ?
		CNT_W'(1) : len_q + 1'b1;
	assign scan_hit = (new_len == cnt_q);

	assign r_idx     = r_q[RIDX_W-1:0];
	assign cur_next  = rg_next_q[r_idx];
	assign cur_limit = rg_limit_q[r_idx];
	assign room      = cur_limit - cur_next;
	assign rg_fit    = (cur_next < cur_limit) && (room >= FRAME_BITS'(cnt_q));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = top_q[ADDR_W-1:0];
		ram_wdata = first_q + FRAME_BITS'(i_q);
		ram_raddr = k_q;
		case (cmd)
			CMD_PUSH:   ram_we = 1'b1;
			CMD_POP_RD: ram_raddr = ADDR_W'(top_q - 1'b1);
			CMD_MV_RD:  ram_raddr = src_q[ADDR_W-1:0];
			CMD_MV_WR: begin
				ram_we    = 1'b1;
				ram_waddr = ADDR_W'(src_q - cnt_top);
				ram_wdata = ram_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd == CMD_PUBLISH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd)
				CMD_ADD_REGION: begin
					if (first_q < end_q && 32'(used_q) < REGION_SLOTS) begin
						used_q <= used_q + 1'b1;
					end
				end
				CMD_PUSH:     top_q <= top_q + 1'b1;
				CMD_POP_DONE: top_q <= top_q - 1'b1;
				CMD_MV_DONE:  top_q <= top_q - cnt_top;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LOAD: begin
				op_q         <= op;
				first_q      <= first_page;
				end_q        <= end_page;
				cnt_q        <= page_count;
				i_q          <= '0;
				res_status_q <= ST_OK;
				res_page_q   <= '0;
				res_stk_q    <= 1'b0;
			end
			CMD_ADD_REGION: begin
				if (first_q < end_q) begin
					if (32'(used_q) < REGION_SLOTS) begin
						rg_next_q[used_q[RIDX_W-1:0]]  <= first_q;
						rg_limit_q[used_q[RIDX_W-1:0]] <= end_q;
					end else begin
						res_status_q <= ST_FULL;
					end
				end
			end
			CMD_FAIL_ZERO: res_status_q <= ST_ZERO;
			CMD_FAIL_OOM:  res_status_q <= ST_OOM;
			CMD_OVERFLOW:  res_status_q <= ST_OVF;
			CMD_PUSH:      i_q <= i_q + 1'b1;
			CMD_POP_DONE: begin
				res_page_q <= ram_rdata;
				res_stk_q  <= 1'b1;
			end
			CMD_SCAN_INIT: begin
				k_q          <= ADDR_W'(top_q - 1'b1);
				len_q        <= '0;
				scan_first_q <= 1'b1;
			end
			CMD_SCAN_CHK: begin
				if (scan_hit) begin
					src_q      <= TOP_W'(k_q) + cnt_top;
					res_page_q <= ram_rdata - FRAME_BITS'(cnt_q - 1'b1);
				end else begin
					k_q          <= k_q - 1'b1;
					prev_q       <= ram_rdata;
					len_q        <= new_len;
					scan_first_q <= 1'b0;
				end
			end
			CMD_MV_WR:   src_q <= src_q + 1'b1;
			CMD_MV_DONE: res_stk_q <= 1'b1;
			CMD_RG_INIT: r_q <= '0;
			CMD_RG_NEXT: r_q <= r_q + 1'b1;
			CMD_RG_TAKE: begin
				res_page_q       <= cur_next;
				rg_next_q[r_idx] <= cur_next + FRAME_BITS'(cnt_q);
			end
			CMD_PUBLISH: begin
				out_status_q <= res_status_q;
				out_page_q   <= res_page_q;
				out_stk_q    <= res_stk_q;
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_page   = out_page_q;
	assign out_stk    = out_stk_q;

	always_comb begin
		stat.op         = op_q;
		stat.cnt_zero   = (cnt_q == '0);
		stat.cnt_one    = (cnt_q == CNT_W'(1));
		stat.top_zero   = (top_q == '0);
		stat.stack_ok   = (32'(cnt_q) <= MAX_RUN) && (32'(cnt_q) <= 32'(top_q));
		stat.full       = (32'(top_q) == FREE_DEPTH);
		stat.pushed_all = (i_q == cnt_q);
		stat.scan_hit   = scan_hit;
		stat.scan_last  = (k_q == '0);
		stat.mv_done    = (src_q == top_q);
		stat.rg_end     = (r_q == used_q);
		stat.rg_fit     = rg_fit;
		stat.out_free   = !out_valid_q || out_ready;
	end

`ifndef SYNTHESIS
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(top_q) <= FREE_DEPTH)
		else $error("free stack count beyond depth");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_PUSH |-> 32'(top_q) < FREE_DEPTH)
		else $error("push into full stack");
	a_move_pair: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_MV_WR |-> $past(cmd) == CMD_MV_RD)
		else $error("move write without its read");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= REGION_SLOTS)
		else $error("region count beyond table size");
`endif

endmodule

### rtl/pfa_ctrl.sv
// ----------------------------------------------------------------
// pfa_ctrl
// sequencer for add, free and allocate, one command to the datapath a cycle
// ----------------------------------------------------------------
module pfa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pfa_pkg::dp_stat_t stat,
	output pfa_pkg::dp_cmd_t  cmd
);
	import pfa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_PUSH,
		S_POP,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_MV,
		S_MV_WR,
		S_RG_START,
		S_RG,
		S_DONE
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				state_d = S_DONE;
				case (stat.op)
					OP_ADD: cmd = CMD_ADD_REGION;
					OP_FREE: begin
						if (stat.cnt_zero) cmd = CMD_FAIL_ZERO;
						else state_d = S_PUSH;
					end
					OP_ALLOC: begin
						if (stat.cnt_zero) begin
							cmd = CMD_FAIL_ZERO;
						end else if (stat.cnt_one && !stat.top_zero) begin
							cmd     = CMD_POP_RD;
							state_d = S_POP;
						end else if (!stat.cnt_one && stat.stack_ok) begin
							cmd     = CMD_SCAN_INIT;
							state_d = S_SCAN_RD;
						end else begin
							state_d = S_RG_START;
						end
					end
					default: ;
				endcase
			end
			S_PUSH: begin
				if (stat.pushed_all) begin
					state_d = S_DONE;
				end else if (stat.full) begin
					cmd     = CMD_OVERFLOW;
					state_d = S_DONE;
				end else begin
					cmd = CMD_PUSH;
				end
			end
			S_POP: begin
				cmd     = CMD_POP_DONE;
				state_d = S_DONE;
			end
			S_SCAN_RD: begin
				cmd     = CMD_SCAN_RD;
				state_d = S_SCAN_CHK;
			end
			S_SCAN_CHK: begin
				cmd = CMD_SCAN_CHK;
				if (stat.scan_hit) state_d = S_MV;
				else if (stat.scan_last) state_d = S_RG_START;
				else state_d = S_SCAN_RD;
			end
			S_MV: begin
				if (stat.mv_done) begin
					cmd     = CMD_MV_DONE;
					state_d = S_DONE;
				end else begin
					cmd     = CMD_MV_RD;
					state_d = S_MV_WR;
				end
			end
			S_MV_WR: begin
				cmd     = CMD_MV_WR;
				state_d = S_MV;
			end
			S_RG_START: begin
				cmd     = CMD_RG_INIT;
				state_d = S_RG;
			end
			S_RG: begin
				if (stat.rg_end) begin
					cmd     = CMD_FAIL_OOM;
					state_d = S_DONE;
				end else if (stat.rg_fit) begin
					cmd     = CMD_RG_TAKE;
					state_d = S_DONE;
				end else begin
					cmd = CMD_RG_NEXT;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd     = CMD_PUBLISH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

`ifndef SYNTHESIS
	a_done_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && stat.out_free |=> state_q == S_IDLE)
		else $error("finished word not published");
	a_load_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_DISPATCH)
		else $error("accepted word not dispatched");
	a_check_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN_CHK |-> $past(state_q) == S_SCAN_RD)
		else $error("scan check without read");
`endif

endmodule

### sim/pfa_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------
// pfa_checker
// watches the request and response streams of the page frame allocator,
// keeps its own copy of the free stack and region table, predicts each
// response word and compares it field by field
// ----------------------------------------------------------------
module pfa_checker
	import pfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,
	input  logic        m_tuser,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [ST_W-1:0]       status;
		logic [FRAME_BITS-1:0] page;
		logic                  from_stack;
	} resp_t;

	logic [FRAME_BITS-1:0] stk [FREE_DEPTH];
	int                    stk_top;
	logic [FRAME_BITS-1:0] rg_next [REGION_SLOTS];
	logic [FRAME_BITS-1:0] rg_lim  [REGION_SLOTS];
	int                    rg_used;
	resp_t                 want_q [$];

	// stack search for a run ascending by one going deeper
	function automatic bit pop_run(int cnt, output logic [FRAME_BITS-1:0] base);
		bit ok;
		base = '0;
		if (cnt > MAX_RUN || cnt > stk_top)
			return 0;
		for (int t = stk_top; t >= cnt; t--) begin
			ok = 1;
			for (int i = 1; i < cnt; i++)
				if ({1'b0, stk[t-1-i]} != {1'b0, stk[t-1]} + (FRAME_BITS + 1)'(i)) begin
					ok = 0;
					break;
				end
			if (ok) begin
				base = stk[t-1];
				for (int j = t; j < stk_top; j++)
					stk[j-cnt] = stk[j];
				stk_top -= cnt;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic bit bump_region(int cnt, output logic [FRAME_BITS-1:0] base);
		base = '0;
		for (int r = 0; r < rg_used; r++)
			if (rg_next[r] < rg_lim[r] && (rg_lim[r] - rg_next[r]) >= cnt) begin
				base = rg_next[r];
				rg_next[r] += FRAME_BITS'(cnt);
				return 1;
			end
		return 0;
	endfunction

	function automatic resp_t predict_word(logic [1:0] op, logic [87:0] d);
		logic [FRAME_BITS-1:0] fp, ep, f;
		int                    cnt;
		resp_t                 w;
		fp  = d[39:0];
		ep  = d[79:40];
		cnt = d[86:80];
		w   = '0;
		case (op)
			OP_ADD: begin
				if (fp < ep) begin
					if (rg_used >= REGION_SLOTS)
						w.status = ST_FULL;
					else begin
						rg_next[rg_used] = fp;
						rg_lim[rg_used]  = ep;
						rg_used++;
					end
				end
			end
			OP_FREE: begin
				if (cnt == 0)
					w.status = ST_ZERO;
				else
					for (int i = 0; i < cnt; i++) begin
						if (stk_top >= FREE_DEPTH) begin
							w.status = ST_OVF;
							break;
						end
						stk[stk_top] = fp + FRAME_BITS'(i);
						stk_top++;
					end
			end
			OP_ALLOC: begin
				if (cnt == 0)
					w.status = ST_ZERO;
				else if (cnt == 1 && stk_top > 0) begin
					stk_top--;
					w.page       = stk[stk_top];
					w.from_stack = 1;
				end else if (cnt > 1 && pop_run(cnt, f)) begin
					w.page       = f;
					w.from_stack = 1;
				end else if (bump_region(cnt, f))
					w.page = f;
				else
					w.status = ST_OOM;
			end
			default: ;
		endcase
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		resp_t want;
		int    errs;
		if (!arst_n) begin
			stk_top    <= 0;
			rg_used    <= 0;
			fail_count <= 0;
			pending    <= 0;
			want_q.delete();
		end else begin
			errs = 0;
			if (s_tvalid && s_tready)
				want_q.push_back(predict_word(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				if (want_q.size() == 0) begin
					$error("unexpected response word %h", m_tdata);
					errs++;
				end else begin
					want = want_q.pop_front();
					if (m_tdata[2:0] !== want.status) begin
						$error("status: expected %0d actual %0d", want.status, m_tdata[2:0]);
						errs++;
					end
					if (m_tdata[42:3] !== want.page) begin
						$error("page_out: expected %h actual %h", want.page, m_tdata[42:3]);
						errs++;
					end
					if (m_tuser !== want.from_stack) begin
						$error("from_free_stack: expected %0d actual %0d",
							want.from_stack, m_tuser);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending    <= want_q.size();
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------
// testbench
// drives requests into the page frame allocator with random gaps and
// output stalls; the checker predicts and compares every response word
// ----------------------------------------------------------------
module testbench;
	import pfa_pkg::*;

	localparam int QUIET_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tuser;
	int          fail_count;
	int          pending;
	bit          calm;      // no idling on either side
	int          quiet;

	page_frame_allocator u_top (.*);

	pfa_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 0;
		else
			m_tready <= calm || ($urandom_range(99) >= 37);
	end

	// watchdog on cycles with nothing accepted
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// send one word, with an optional idle gap first
	task automatic send_req(logic [1:0] op, logic [39:0] fp, logic [39:0] ep, int cnt);
		if (!calm)
			while ($urandom_range(99) < 37) begin
				s_tvalid <= 0;
				@(posedge clk);
			end
		s_tvalid <= 1;
		s_tuser  <= op;
		s_tdata  <= {1'b0, 7'(cnt), ep, fp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	function automatic logic [39:0] rnd_frame();
		return 40'({$urandom(), $urandom()});
	endfunction

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [39:0] base;
		int          k;
		quiet    = 0;
		calm     = 0;
		arst_n   = 0;
		s_tvalid = 0;
		s_tdata  = '0;
		s_tuser  = OP_ADD;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty allocator, zero counts, unknown op, field extremes
		send_req(OP_ALLOC, 0, 0, 1);
		send_req(OP_ALLOC, 0, 0, 0);
		send_req(OP_FREE, 0, 0, 0);
		send_req(2'd3, '1, '1, 127);
		send_req(OP_ADD, 40'd5, 40'd5, 0);          // empty region
		send_req(OP_ADD, 40'd9, 40'd3, 0);          // reversed range
		send_req(OP_ADD, 40'hFF_FFFF_FF00, '1, 0);  // top of frame space
		send_req(OP_ADD, 40'h1000, 40'h1010, 0);
		send_req(OP_ALLOC, 0, 0, 64);               // too large for the 0x1000 region
		send_req(OP_ALLOC, 0, 0, 127);
		send_req(OP_FREE, '1 - 2, 0, 5);            // frame wrap
		send_req(OP_ALLOC, 0, 0, 3);
		send_req(OP_ALLOC, 0, 0, 1);
		send_req(OP_FREE, 40'h500, 0, 64);
		send_req(OP_ALLOC, 0, 0, 64);               // longest stack run
		send_req(OP_FREE, 40'h700, 0, 100);
		send_req(OP_ALLOC, 0, 0, 65);               // stack not searched
		send_req(OP_ALLOC, 0, 0, 10);
		send_req(OP_ALLOC, 0, 0, 120);
		// the sender holds off until every word is back
		drain();
		// stack overflow
		for (k = 0; k < 9; k++)
			send_req(OP_FREE, 40'h10000 + k * 200, 0, 127);
		// fill the region table then three more
		for (k = 0; k < 33; k++)
			send_req(OP_ADD, 40'h20000 + k * 50, 40'h20000 + k * 50 + 40, 0);
		for (k = 0; k < 12; k++)
			send_req(OP_ALLOC, 0, 0, 1 + $urandom_range(127));
		drain();

		// random part, with one calm stretch
		for (k = 0; k < 880; k++) begin
			calm = (k >= 300 && k < 420);
			base = ($urandom_range(3) == 0) ? rnd_frame() : 40'($urandom_range(4095));
			case ($urandom_range(9))
				0:       send_req(OP_ADD, base, ($urandom_range(3) == 0) ? rnd_frame()
					: base + $urandom_range(200), 0);
				1, 2, 3: send_req(OP_FREE, base, 0, $urandom_range(20) == 0 ? 0
					: 1 + $urandom_range(($urandom_range(5) == 0) ? 127 : 8));
				4:       send_req(2'd3, rnd_frame(), rnd_frame(), $urandom_range(127));
				default: send_req(OP_ALLOC, rnd_frame(), rnd_frame(),
					$urandom_range(20) == 0 ? 0
					: 1 + $urandom_range(($urandom_range(7) == 0) ? 126 : 6));
			endcase
		end
		calm = 0;

		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### page_frame_allocator.f
rtl/pfa_pkg.sv
rtl/pfa_ram.sv
rtl/pfa_dp.sv
rtl/pfa_ctrl.sv
rtl/page_frame_allocator.sv
sim/pfa_checker.sv
sim/testbench.sv
